@@ design/grc_pkg.sv @@
// ----------------------------------------------------------------------------
// grc_pkg
// shared types, widths and constants of the grid ray caster
// ----------------------------------------------------------------------------
package grc_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;
	localparam int MAP_SIDE      = 32;
	localparam int TEX_SIDE      = 64;
	localparam int TEXTURE_COUNT = 8;

	localparam int MAP_BITS  = $clog2(MAP_SIDE);
	localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
	localparam int ADDR_BITS = 2 * MAP_BITS;
	localparam int TEX_BITS  = $clog2(TEX_SIDE);

	// field widths
	localparam int OP_W    = 1;
	localparam int CELL_W  = 5;
	localparam int VAL_W   = 8;
	localparam int COL_W   = 10;
	localparam int POS_W   = 21;
	localparam int VEC_W   = 18;
	localparam int TIDX_W  = 3;
	localparam int TCOL_W  = 6;
	localparam int ROW_W   = 9;
	localparam int TSTEP_W = 23;
	localparam int TSTART_W = 22;
	localparam int DIST_W  = 22;

	localparam int ONE_Q16 = 65536;

	// camera x: floor(col * 2^17 / SCREEN_WIDTH) - 1.0
	localparam int CAMX_W    = COL_W + 17;
	localparam int CAM_SHIFT = 40;
	localparam logic [31:0] CAM_RECIP =
		32'(((64'd1 << CAM_SHIFT) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));
	localparam int CAMP_W = CAMX_W + 32;
	localparam int CAMQ_W = 18;
	localparam int CAM_W  = CAMQ_W + 1;
	localparam int PRD_W  = VEC_W + CAM_W;
	localparam int RAY_W  = 22;

	// distances
	localparam int FAR_W = 41;
	localparam logic [FAR_W-1:0] FAR_Q16 = {1'b1, {(FAR_W-1){1'b0}}};
	localparam int SUM_W = 48;
	localparam int LH_W  = $clog2(SCREEN_HEIGHT * ONE_Q16 + 1);
	localparam int STEPQ_W = $clog2(TEX_SIDE * ONE_Q16 + 1);
	localparam int HALF_H = SCREEN_HEIGHT / 2;
	localparam int WALK_LIMIT = 2 * MAP_SIDE + 2;
	localparam int N_W = $clog2(WALK_LIMIT + 1);

	// shared divider
	localparam int DIV_NW = 33;
	localparam int DIV_DW = FAR_W;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	// queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	// register map
	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_POS_X   = 3'd0;
	localparam logic [2:0] REG_POS_Y   = 3'd1;
	localparam logic [2:0] REG_DIR_X   = 3'd2;
	localparam logic [2:0] REG_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;

	typedef struct packed {
		logic [POS_W-1:0]        pos_x;
		logic [POS_W-1:0]        pos_y;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] plane_x;
		logic signed [VEC_W-1:0] plane_y;
	} grc_cfg_t;

	typedef struct packed {
		logic                    opcode;
		logic [CELL_W-1:0]       cell_x;
		logic [CELL_W-1:0]       cell_y;
		logic [VAL_W-1:0]        cell_value;
		logic [COL_W-1:0]        column;
		logic signed [RAY_W-1:0] ray_x;
		logic signed [RAY_W-1:0] ray_y;
	} grc_job_t;

endpackage

@@ design/grc_if.sv @@
// ----------------------------------------------------------------------------
// grc channel interfaces
// command channel into the caster and wall stripe channel out of it
// ----------------------------------------------------------------------------
interface grc_cmd_if import grc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [CELL_W-1:0] cell_x;
	logic [CELL_W-1:0] cell_y;
	logic [VAL_W-1:0]  cell_value;
	logic [COL_W-1:0]  screen_column;

	modport source (output valid, opcode, cell_x, cell_y, cell_value, screen_column,
		input ready);
	modport sink (input valid, opcode, cell_x, cell_y, cell_value, screen_column,
		output ready);
endinterface

interface grc_res_if import grc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COL_W-1:0]    column_out;
	logic                no_hit;
	logic                wall_side;
	logic [TIDX_W-1:0]   texture_index;
	logic [TCOL_W-1:0]   texture_column;
	logic [ROW_W-1:0]    first_row;
	logic [ROW_W-1:0]    last_row;
	logic [TSTEP_W-1:0]  texel_step;
	logic [TSTART_W-1:0] texel_start;
	logic [DIST_W-1:0]   wall_distance;

	modport source (output valid, column_out, no_hit, wall_side, texture_index,
		texture_column, first_row, last_row, texel_step, texel_start, wall_distance,
		input ready);
	modport sink (input valid, column_out, no_hit, wall_side, texture_index,
		texture_column, first_row, last_row, texel_step, texel_start, wall_distance,
		output ready);
endinterface

@@ design/grc_ram.sv @@
// ----------------------------------------------------------------------------
// grc_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module grc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/grc_div.sv @@
// ----------------------------------------------------------------------------
// grc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grc_div import grc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == DIV_CW'(1));
			if (start) begin
				cnt_q <= DIV_CW'(DIV_NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : DIV_DW'(trial);
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ design/grc_queue.sv @@
// ----------------------------------------------------------------------------
// grc_queue
// short job queue between the front and back of the caster
// ----------------------------------------------------------------------------
module grc_queue import grc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  grc_job_t push_job,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output grc_job_t head
);

	grc_job_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

@@ design/grc_front.sv @@
// ----------------------------------------------------------------------------
// grc_front
// takes commands, forms the camera ray of a cast, queues the job
// ----------------------------------------------------------------------------
module grc_front import grc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	grc_cmd_if.sink  cmd,
	input  grc_cfg_t cfg,
	input  logic     enable,
	input  logic     full,
	output logic     push,
	output grc_job_t push_job
);

	typedef enum logic [1:0] {F_IDLE, F_CAM, F_RAY, F_PUSH} state_t;

	state_t                  state_q;
	grc_job_t                job_q;
	logic signed [CAM_W-1:0] cam_q;
	logic [CAMP_W-1:0]       cam_prod;
	logic signed [PRD_W-1:0] px;
	logic signed [PRD_W-1:0] py;

	assign cmd.ready = (state_q == F_IDLE) && enable;
	assign push      = (state_q == F_PUSH) && !full;
	assign push_job  = job_q;

	assign cam_prod = CAMP_W'({job_q.column, 17'b0}) * CAMP_W'(CAM_RECIP);
	assign px = PRD_W'(cfg.plane_x) * PRD_W'(cam_q);
	assign py = PRD_W'(cfg.plane_y) * PRD_W'(cam_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						state_q <= (cmd.opcode == OP_CAST) ? F_CAM : F_PUSH;
					end
				end
				F_CAM:  state_q <= F_RAY;
				F_RAY:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && cmd.valid && cmd.ready) begin
			job_q.opcode     <= cmd.opcode;
			job_q.cell_x     <= cmd.cell_x;
			job_q.cell_y     <= cmd.cell_y;
			job_q.cell_value <= cmd.cell_value;
			job_q.column     <= cmd.screen_column;
			job_q.ray_x      <= '0;
			job_q.ray_y      <= '0;
		end
		if (state_q == F_CAM) begin
			cam_q <= $signed({1'b0, cam_prod[CAM_SHIFT +: CAMQ_W]}) - CAM_W'(ONE_Q16);
		end
		if (state_q == F_RAY) begin
			job_q.ray_x <= RAY_W'(cfg.dir_x) + RAY_W'(px >>> 16);
			job_q.ray_y <= RAY_W'(cfg.dir_y) + RAY_W'(py >>> 16);
		end
	end

endmodule

@@ design/grc_back.sv @@
// ----------------------------------------------------------------------------
// grc_back
// map writes, grid walk and wall stripe arithmetic
// ----------------------------------------------------------------------------
module grc_back import grc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  grc_cfg_t cfg,
	input  grc_job_t job,
	input  logic     empty,
	output logic     pop,
	output logic     clearing,
	grc_res_if.source res
);

	typedef enum logic [4:0] {
		B_CLEAR, B_IDLE, B_DX, B_DXW, B_DY, B_DYW, B_SX, B_SY, B_STEP, B_CHECK,
		B_DIST, B_LH, B_LHW, B_ROWS, B_STW, B_FIN, B_OUT
	} state_t;

	state_t                  state_q;
	logic [ADDR_BITS-1:0]    clr_q;
	logic [COL_W-1:0]        col_q;
	logic signed [RAY_W-1:0] rx_q, ry_q;
	logic [MAP_BITS-1:0]     mx_q, my_q;
	logic [FAR_W-1:0]        dx_q, dy_q, dist_q;
	logic [SUM_W-1:0]        sx_q, sy_q;
	logic                    side_q, nohit_q;
	logic [N_W-1:0]          n_q;
	logic [VAL_W-1:0]        cell_q;
	logic [LH_W-1:0]         lh_q;
	logic [LH_W-1:0]         first_q, last_q;
	logic [LH_W-2:0]         offs_q;
	logic [STEPQ_W-1:0]      step_q;
	logic [TEX_BITS-1:0]     tex_q;
	logic [LH_W+STEPQ_W-2:0] start_q;

	// output register
	logic                valid_q;
	logic [COL_W-1:0]    o_col_q;
	logic                o_nohit_q, o_side_q;
	logic [TIDX_W-1:0]   o_tidx_q;
	logic [TCOL_W-1:0]   o_tcol_q;
	logic [ROW_W-1:0]    o_first_q, o_last_q;
	logic [TSTEP_W-1:0]  o_step_q;
	logic [TSTART_W-1:0] o_start_q;
	logic [DIST_W-1:0]   o_dist_q;

	logic                 rx_neg, ry_neg, step_x, leave, can_load, viewer_out;
	logic [MAP_BITS-1:0]  nx, ny;
	logic [RAY_W-1:0]     abs_rx, abs_ry;
	logic                 ram_we;
	logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
	logic [VAL_W-1:0]     ram_wdata, ram_rdata;
	logic                 div_start, div_done;
	logic [DIV_NW-1:0]    div_num, div_quo;
	logic [DIV_DW-1:0]    div_den;
	logic [15:0]          ss_frac;
	logic                 ss_neg;
	logic [FAR_W-1:0]     ss_delta;
	logic [16:0]          ss_mul;
	logic [49:0]          ss_prod;
	logic [SUM_W-1:0]     ss_start;
	logic [SUM_W-1:0]     dist_raw;
	logic [LH_W-2:0]      half;
	logic [31:0]          tprod;
	logic [15:0]          hit_frac;
	logic [TEX_BITS-1:0]  tex_raw;
	logic                 mirror;
	logic [VAL_W-1:0]     tidx;

	assign rx_neg = rx_q < 0;
	assign ry_neg = ry_q < 0;
	assign abs_rx = rx_neg ? RAY_W'(-rx_q) : RAY_W'(rx_q);
	assign abs_ry = ry_neg ? RAY_W'(-ry_q) : RAY_W'(ry_q);
	assign viewer_out = ((cfg.pos_x >> 16) >= POS_W'(MAP_SIDE))
		|| ((cfg.pos_y >> 16) >= POS_W'(MAP_SIDE));

	// walk step
	assign step_x = sx_q < sy_q;
	assign nx = rx_neg ? mx_q - 1'b1 : mx_q + 1'b1;
	assign ny = ry_neg ? my_q - 1'b1 : my_q + 1'b1;
	assign leave = step_x ? (rx_neg ? (mx_q == '0) : (mx_q == MAP_BITS'(MAP_SIDE - 1)))
		: (ry_neg ? (my_q == '0) : (my_q == MAP_BITS'(MAP_SIDE - 1)));
	assign ram_raddr = step_x ? {nx, my_q} : {mx_q, ny};

	// side distance start, shared by both axes
	assign ss_frac  = (state_q == B_SY) ? cfg.pos_y[15:0] : cfg.pos_x[15:0];
	assign ss_neg   = (state_q == B_SY) ? ry_neg : rx_neg;
	assign ss_delta = (state_q == B_SY) ? dy_q : dx_q;
	assign ss_mul   = ss_neg ? {1'b0, ss_frac} : 17'(ONE_Q16) - {1'b0, ss_frac};
	assign ss_prod  = 50'(ss_mul) * 50'(ss_delta[32:0]);
	assign ss_start = ss_delta[FAR_W-1] ? SUM_W'({ss_mul, 24'b0}) : SUM_W'(ss_prod >> 16);

	assign dist_raw = side_q ? sy_q - SUM_W'(dy_q) : sx_q - SUM_W'(dx_q);
	assign half = lh_q[LH_W-1:1];

	// wall hit point along the face
	assign tprod = dist_q[31:0] * 32'(side_q ? rx_q : ry_q);
	assign hit_frac = (side_q ? cfg.pos_x[15:0] : cfg.pos_y[15:0]) + tprod[31:16];
	assign tex_raw = hit_frac[15 -: TEX_BITS];
	assign mirror = (!side_q && rx_q > 0) || (side_q && ry_neg);
	assign tidx = (cell_q - 1'b1) >= VAL_W'(TEXTURE_COUNT) ? VAL_W'(TEXTURE_COUNT - 1)
		: cell_q - 1'b1;

	assign can_load = !valid_q || res.ready;
	assign clearing = state_q == B_CLEAR;
	assign pop = (state_q == B_IDLE) && !empty;

	// map writes and the clearing sweep
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == B_CLEAR) begin
			ram_we = 1'b1;
		end else if (pop && job.opcode == OP_WRITE) begin
			ram_we = (32'(job.cell_x) < MAP_SIDE) && (32'(job.cell_y) < MAP_SIDE);
			ram_waddr = {job.cell_x[MAP_BITS-1:0], job.cell_y[MAP_BITS-1:0]};
			ram_wdata = job.cell_value;
		end
	end

	// divider requests
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			B_DX: begin
				div_start = rx_q != 0;
				div_num   = DIV_NW'(1) << 32;
				div_den   = DIV_DW'(abs_rx);
			end
			B_DY: begin
				div_start = ry_q != 0;
				div_num   = DIV_NW'(1) << 32;
				div_den   = DIV_DW'(abs_ry);
			end
			B_LH: begin
				div_start = dist_q != '0;
				div_num   = DIV_NW'(SCREEN_HEIGHT) << 16;
				div_den   = dist_q;
			end
			B_ROWS: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(TEX_SIDE) << 16;
				div_den   = DIV_DW'(lh_q);
			end
			default: div_start = 1'b0;
		endcase
	end

	grc_ram #(.WIDTH(VAL_W), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (state_q == B_OUT && can_load) begin
				valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop && job.opcode == OP_CAST) begin
						state_q <= viewer_out ? B_OUT : B_DX;
					end
				end
				B_DX:  state_q <= (rx_q != 0) ? B_DXW : B_DY;
				B_DXW: state_q <= div_done ? B_DY : B_DXW;
				B_DY:  state_q <= (ry_q != 0) ? B_DYW : B_SX;
				B_DYW: state_q <= div_done ? B_SX : B_DYW;
				B_SX:  state_q <= B_SY;
				B_SY:  state_q <= B_STEP;
				B_STEP: begin
					state_q <= (n_q == N_W'(WALK_LIMIT) || leave) ? B_OUT : B_CHECK;
				end
				B_CHECK: state_q <= (ram_rdata != '0) ? B_DIST : B_STEP;
				B_DIST:  state_q <= B_LH;
				B_LH:    state_q <= (dist_q != '0) ? B_LHW : B_ROWS;
				B_LHW:   state_q <= div_done ? B_ROWS : B_LHW;
				B_ROWS:  state_q <= B_STW;
				B_STW:   state_q <= div_done ? B_FIN : B_STW;
				B_FIN:   state_q <= B_OUT;
				B_OUT: begin
					if (can_load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				col_q   <= job.column;
				rx_q    <= job.ray_x;
				ry_q    <= job.ray_y;
				mx_q    <= cfg.pos_x[16 +: MAP_BITS];
				my_q    <= cfg.pos_y[16 +: MAP_BITS];
				nohit_q <= viewer_out;
				n_q     <= '0;
				side_q  <= 1'b0;
			end
			B_DX: dx_q <= FAR_Q16;
			B_DXW: begin
				if (div_done) begin
					dx_q <= FAR_W'(div_quo);
				end
			end
			B_DY: dy_q <= FAR_Q16;
			B_DYW: begin
				if (div_done) begin
					dy_q <= FAR_W'(div_quo);
				end
			end
			B_SX: sx_q <= ss_start;
			B_SY: sy_q <= ss_start;
			B_STEP: begin
				n_q <= n_q + 1'b1;
				if (n_q == N_W'(WALK_LIMIT) || leave) begin
					nohit_q <= 1'b1;
				end else if (step_x) begin
					sx_q   <= sx_q + SUM_W'(dx_q);
					mx_q   <= nx;
					side_q <= 1'b0;
				end else begin
					sy_q   <= sy_q + SUM_W'(dy_q);
					my_q   <= ny;
					side_q <= 1'b1;
				end
			end
			B_CHECK: cell_q <= ram_rdata;
			B_DIST: begin
				dist_q <= (dist_raw > SUM_W'(FAR_Q16)) ? FAR_Q16 : dist_raw[FAR_W-1:0];
			end
			B_LH: lh_q <= LH_W'(SCREEN_HEIGHT * ONE_Q16);
			B_LHW: begin
				if (div_done) begin
					lh_q <= (div_quo == '0) ? LH_W'(1) : LH_W'(div_quo);
				end
			end
			B_ROWS: begin
				first_q <= (half >= (LH_W-1)'(HALF_H)) ? '0
					: LH_W'((LH_W-1)'(HALF_H) - half);
				last_q  <= (LH_W'(half) + LH_W'(HALF_H) >= LH_W'(SCREEN_HEIGHT - 1))
					? LH_W'(SCREEN_HEIGHT - 1) : LH_W'(half) + LH_W'(HALF_H);
				offs_q  <= (half > (LH_W-1)'(HALF_H)) ? half - (LH_W-1)'(HALF_H) : '0;
				tex_q   <= mirror ? ~tex_raw : tex_raw;
			end
			B_STW: begin
				if (div_done) begin
					step_q <= STEPQ_W'(div_quo);
				end
			end
			B_FIN: start_q <= (LH_W+STEPQ_W-1)'(offs_q) * (LH_W+STEPQ_W-1)'(step_q);
			B_OUT: begin
				if (can_load) begin
					o_col_q   <= col_q;
					o_nohit_q <= nohit_q;
					o_side_q  <= nohit_q ? 1'b0 : side_q;
					o_tidx_q  <= nohit_q ? '0 : TIDX_W'(tidx);
					o_tcol_q  <= nohit_q ? '0 : TCOL_W'(tex_q);
					o_first_q <= nohit_q ? '0 : ROW_W'(first_q);
					o_last_q  <= nohit_q ? '0 : ROW_W'(last_q);
					o_step_q  <= nohit_q ? '0
						: (step_q > STEPQ_W'({TSTEP_W{1'b1}})) ? '1 : TSTEP_W'(step_q);
					o_start_q <= nohit_q ? '0
						: (start_q > (LH_W+STEPQ_W-1)'({TSTART_W{1'b1}})) ? '1
						: TSTART_W'(start_q);
					o_dist_q  <= nohit_q ? '0
						: (dist_q > FAR_W'({DIST_W{1'b1}})) ? '1 : DIST_W'(dist_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid          = valid_q;
	assign res.column_out     = o_col_q;
	assign res.no_hit         = o_nohit_q;
	assign res.wall_side      = o_side_q;
	assign res.texture_index  = o_tidx_q;
	assign res.texture_column = o_tcol_q;
	assign res.first_row      = o_first_q;
	assign res.last_row       = o_last_q;
	assign res.texel_step     = o_step_q;
	assign res.texel_start    = o_start_q;
	assign res.wall_distance  = o_dist_q;

endmodule

@@ design/grid_ray_caster_column.sv @@
// ----------------------------------------------------------------------------
// grid_ray_caster_column
// grid map store plus DDA ray caster returning one textured wall stripe
// ----------------------------------------------------------------------------
// usage
// - cmd channel: opcode write stores one map cell, opcode cast names a column
// - res channel: one wall stripe per cast transfer, nothing for a write
// - viewer position, direction and camera plane sit in the apb registers;
//   change them only while no cast is in flight
// - the front takes a command, forms the camera ray in its cam and ray states and puts
//   the job into a four deep queue; the back walks the grid on its own
// - back work per cast: two delta divisions (skipped for a zero ray
//   component), a step and a check state per grid step (map ram read),
//   then on a hit two more divisions for line height and texel step;
//   the shared bit-serial divider sets most of the cast time
// - a map write is done in the back's idle state as the job is popped
// - after reset the back clears the 1024 cell map, one cell a cycle; cmd
//   ready stays low during the clear, register writes are taken
// - a stalled res leaves the finished stripe in the output register; the
//   front keeps filling the queue and the back runs on until its next
//   stripe has to wait
// ----------------------------------------------------------------------------
module grid_ray_caster_column import grc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	grc_cmd_if.sink            cmd,
	grc_res_if.source          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	grc_cfg_t   cfg_q;
	logic [2:0] reg_sel;
	logic       cfg_wr;

	// queue hookup
	logic     q_push, q_full, q_pop, q_empty;
	grc_job_t q_in, q_head;
	logic     clearing;

	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x   <= POS_W'(1441792);
			cfg_q.pos_y   <= POS_W'(786432);
			cfg_q.dir_x   <= -VEC_W'(65536);
			cfg_q.dir_y   <= '0;
			cfg_q.plane_x <= '0;
			cfg_q.plane_y <= VEC_W'(43254);
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_POS_X:   cfg_q.pos_x   <= pwdata[POS_W-1:0];
				REG_POS_Y:   cfg_q.pos_y   <= pwdata[POS_W-1:0];
				REG_DIR_X:   cfg_q.dir_x   <= pwdata[VEC_W-1:0];
				REG_DIR_Y:   cfg_q.dir_y   <= pwdata[VEC_W-1:0];
				REG_PLANE_X: cfg_q.plane_x <= pwdata[VEC_W-1:0];
				REG_PLANE_Y: cfg_q.plane_y <= pwdata[VEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_sel)
			REG_POS_X:   prdata = 32'(cfg_q.pos_x);
			REG_POS_Y:   prdata = 32'(cfg_q.pos_y);
			REG_DIR_X:   prdata = 32'(unsigned'(cfg_q.dir_x));
			REG_DIR_Y:   prdata = 32'(unsigned'(cfg_q.dir_y));
			REG_PLANE_X: prdata = 32'(unsigned'(cfg_q.plane_x));
			REG_PLANE_Y: prdata = 32'(unsigned'(cfg_q.plane_y));
			default:     prdata = '0;
		endcase
	end

	// front: command intake and ray setup
	grc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.enable   (!clearing),
		.full     (q_full),
		.push     (q_push),
		.push_job (q_in)
	);

	// job queue decoupling front and back
	grc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// back: map store, grid walk, stripe math, output register
	grc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job      (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.clearing (clearing),
		.res      (res)
	);

	// checks
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue push while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue pop while empty");
	a_no_cmd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !(cmd.valid && cmd.ready)) else $error("command taken during clear");
	a_no_res_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !res.valid) else $error("result during clear");

endmodule
